@@ hw/rtl/csra_pkg.sv @@
// Shared types and constants for the counting-sort placement block.
// Depends on nothing; every other file but csra_cursor_ram imports it.
package csra_pkg;

  localparam int unsigned MAX_GROUPS = 1024;
  localparam int unsigned ROW_BITS   = 20;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SIZE_W = 20;
  localparam int unsigned ID_W   = 10;
  localparam int unsigned POS_W  = 20;

  localparam int unsigned GRP_IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned GL_W      = $clog2(MAX_GROUPS + 1);
  localparam int unsigned TOT_W     = ROW_BITS + 1;
  localparam int unsigned SUM_W     = ((ROW_BITS > SIZE_W) ? ROW_BITS : SIZE_W) + 2;
  localparam int unsigned ID_CMP_W  = (GL_W > ID_W) ? GL_W : ID_W;

  localparam logic [SUM_W-1:0] ROW_MAX = SUM_W'((64'd1 << ROW_BITS) - 64'd1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PLACE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BAD_ID = 2'd1,
    ERR_FULL   = 2'd2,
    ERR_OVF    = 2'd3
  } err_t;

  // One accepted word held in the execute stage.
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SIZE_W-1:0]    size;
    logic [ID_W-1:0]      gid;
    logic [GRP_IDX_W-1:0] idx;
  } item_t;

  // Cursor write-back request.
  typedef struct packed {
    logic                 en;
    logic [GRP_IDX_W-1:0] addr;
    logic [ROW_BITS-1:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             sorted;
    err_t             error;
  } result_t;

endpackage

@@ hw/rtl/csra_cursor_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds the group cursor table.
module csra_cursor_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 20,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read returns the old contents when it hits the entry written this cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/csra_exec.sv @@
// Execute stage: batch counters, command decode, cursor update and error checks.
// Depends on csra_pkg.
module csra_exec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  csra_pkg::item_t               item,
  input  logic [csra_pkg::ROW_BITS-1:0] cursor,
  output csra_pkg::wr_req_t             wr,
  output csra_pkg::result_t             res
);
  import csra_pkg::*;

  logic [GL_W-1:0]     gl_r, gl_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;
  logic [ROW_BITS-1:0] rows_r, rows_nxt;
  logic                flag_r, flag_nxt;

  logic [SUM_W-1:0]    sum;
  logic [ROW_BITS-1:0] pos;
  logic [ROW_BITS-1:0] row;
  logic                full;
  logic                ovf;
  logic                bad_id;
  logic                wr_en;

  assign sum    = SUM_W'(total_r) + SUM_W'(item.size);
  assign full   = (gl_r >= GL_W'(MAX_GROUPS));
  assign ovf    = (sum > ROW_MAX);
  assign bad_id = (item.gid == '0) || (ID_CMP_W'(item.gid) > ID_CMP_W'(gl_r));
  assign pos    = cursor + ROW_BITS'(1);
  assign row    = rows_r + ROW_BITS'(1);

  always_comb begin
    gl_nxt       = gl_r;
    total_nxt    = total_r;
    rows_nxt     = rows_r;
    flag_nxt     = flag_r;
    wr_en        = 1'b0;
    wr.addr      = item.idx;
    wr.data      = pos;
    res.position = '0;
    res.error    = ERR_OK;
    unique case (item.cmd)
      CMD_CLEAR: begin
        gl_nxt    = '0;
        total_nxt = '0;
        rows_nxt  = '0;
        flag_nxt  = 1'b1;
      end
      CMD_LOAD: begin
        if (full) begin
          res.error = ERR_FULL;
        end else if (ovf) begin
          res.error = ERR_OVF;
        end else begin
          wr_en        = 1'b1;
          wr.addr      = gl_r[GRP_IDX_W-1:0];
          wr.data      = ROW_BITS'(total_r);
          gl_nxt       = gl_r + GL_W'(1);
          total_nxt    = TOT_W'(sum);
          res.position = POS_W'(total_r);
        end
      end
      CMD_PLACE: begin
        if (bad_id) begin
          res.error = ERR_BAD_ID;
        end else begin
          wr_en        = 1'b1;
          rows_nxt     = row;
          flag_nxt     = flag_r & (pos == row);
          res.position = POS_W'(pos);
        end
      end
      default: begin
      end
    endcase
    res.sorted = flag_nxt;
    wr.en      = wr_en & adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gl_r    <= '0;
      total_r <= '0;
      rows_r  <= '0;
      flag_r  <= 1'b1;
    end else if (adv) begin
      gl_r    <= gl_nxt;
      total_r <= total_nxt;
      rows_r  <= rows_nxt;
      flag_r  <= flag_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_gl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gl_r <= GL_W'(MAX_GROUPS))
    else $error("group count exceeds table size");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(total_r) <= ROW_MAX)
    else $error("running total exceeds row range");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!flag_r && !(adv && item.cmd == CMD_CLEAR)) |=> !flag_r)
    else $error("in-order flag set again without a clear");
`endif

endmodule

@@ hw/rtl/counting_sort_rank_assign.sv @@
// Counting-sort placement top level: each word passes stage one and the output register.
// Throughput is one word per cycle unless out_ready stalls; one cursor RAM RMW sets it.
// Reset is synchronous, active low; it clears the batch counters and the pipeline.
// The cursor RAM is not cleared; a batch only reads entries its own loads wrote.
// Depends on csra_pkg, csra_cursor_ram and csra_exec.
module counting_sort_rank_assign (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [csra_pkg::CMD_W-1:0]  in_cmd,
  input  logic [csra_pkg::SIZE_W-1:0] in_group_size,
  input  logic [csra_pkg::ID_W-1:0]   in_group_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csra_pkg::POS_W-1:0]  out_position,
  output logic                        out_sorted_so_far,
  output logic [1:0]                  out_error
);
  import csra_pkg::*;

  // Stage one holds the accepted word while its cursor read is in flight.
  // The RAM read is issued at acceptance, so the data is ready when stage one executes.
  item_t               s1_r;
  logic                s1_valid_r;
  logic                s1_adv;
  logic                in_acc;
  logic [GRP_IDX_W-1:0] rd_addr;
  logic [ROW_BITS-1:0] rd_data;

  // Forwarding: when the write-back of the executing word hits the entry being
  // read in the same cycle, the RAM returns stale data, so the new value is kept.
  logic                fwd_hit_r;
  logic [ROW_BITS-1:0] fwd_data_r;
  logic [ROW_BITS-1:0] cursor;

  wr_req_t             wr;
  result_t             res;

  // Output register; it decouples the result side from the execute stage.
  result_t             out_r;
  logic                out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign rd_addr  = GRP_IDX_W'(in_group_id) - GRP_IDX_W'(1);
  assign cursor   = fwd_hit_r ? fwd_data_r : rd_data;

  csra_cursor_ram #(
    .DEPTH (MAX_GROUPS),
    .WIDTH (ROW_BITS),
    .AW    (GRP_IDX_W)
  ) u_cursor_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  csra_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .item   (s1_r),
    .cursor (cursor),
    .wr     (wr),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= wr.en && (wr.addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.cmd   <= in_cmd;
      s1_r.size  <= in_group_size;
      s1_r.gid   <= in_group_id;
      s1_r.idx   <= rd_addr;
      fwd_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_r.position;
  assign out_sorted_so_far = out_r.sorted;
  assign out_error         = out_r.error;

`ifndef ASSERT_OFF
  a_wr_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> s1_adv)
    else $error("cursor write without the execute stage advancing");

  a_acc_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted word did not reach the execute stage");

  a_err_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error != ERR_OK) |-> (out_r.position == '0))
    else $error("error word carries a nonzero position");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stalled execute stage lost its word");
`endif

endmodule

@@ sim/counting_sort_rank_assign_tb.sv @@
// Self-checking testbench for the counting-sort placement block (counting_sort_rank_assign).
// Depends on csra_pkg for the command and error codes, the result layout and the sizes.
// A directed table comes first, then random batches checked against a built-in predictor.
module counting_sort_rank_assign_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csra_pkg::*;

  // The only command code that the package does not name: the block ignores it.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  // The largest legal running total is all ones at ROW_BITS.
  localparam logic [TOT_W:0] ROW_LIMIT = (TOT_W + 1)'((64'd1 << ROW_BITS) - 64'd1);
  localparam int unsigned ITEM_TARGET   = 1550;
  localparam int unsigned NUM_DIRECTED  = 22;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned MAX_PRINTED   = 60;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd        = '0;
  logic [SIZE_W-1:0] in_group_size = '0;
  logic [ID_W-1:0]   in_group_id   = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [POS_W-1:0]  out_position;
  logic              out_sorted_so_far;
  logic [1:0]        out_error;

  counting_sort_rank_assign DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_group_size    (in_group_size),
    .in_group_id      (in_group_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_sorted_so_far(out_sorted_so_far),
    .out_error        (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The slowest correct run is roughly 2700 words with the widest drawn gaps, plus the
  // long output hold. That is near 1.1 ms; the limit below leaves ample margin.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Placement predictor. It keeps its own copy of the batch state and computes,
  // for each accepted input word, the result word that the block must return.
  // ---------------------------------------------------------------------------
  logic [ROW_BITS-1:0] model_cursor [MAX_GROUPS];
  int unsigned         model_loaded   = 0;
  logic [TOT_W-1:0]    model_total    = '0;
  logic [ROW_BITS-1:0] model_placed   = '0;
  logic                model_in_order = 1'b1;

  task automatic predict_placement(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                                   input logic [ID_W-1:0] gid, output result_t res);
    logic [TOT_W:0]      new_total;
    logic [ROW_BITS-1:0] pos;
    res = '{position: '0, sorted: 1'b0, error: ERR_OK};
    case (cmd)
      CMD_CLEAR: begin
        // The cursor entries survive a clear; only the counters restart.
        model_loaded   = 0;
        model_total    = '0;
        model_placed   = '0;
        model_in_order = 1'b1;
      end
      CMD_LOAD: begin
        new_total = {1'b0, model_total} + size;
        if (model_loaded >= MAX_GROUPS) begin
          res.error = ERR_FULL;
        end else if (new_total > ROW_LIMIT) begin
          res.error = ERR_OVF;
        end else begin
          // The new group starts where the previous groups end.
          model_cursor[model_loaded] = model_total[ROW_BITS-1:0];
          res.position               = model_total[ROW_BITS-1:0];
          model_loaded++;
          model_total = new_total[TOT_W-1:0];
        end
      end
      CMD_PLACE: begin
        if (gid == '0 || gid > model_loaded) begin
          res.error = ERR_BAD_ID;
        end else begin
          // Pre-increment; a group that overruns its size walks into the next
          // group's positions and wraps at the row width.
          pos                        = model_cursor[gid - 1'b1] + 1'b1;
          model_cursor[gid - 1'b1]   = pos;
          model_placed               = model_placed + 1'b1;
          if (pos != model_placed) model_in_order = 1'b0;
          res.position = pos;
        end
      end
      default: ;
    endcase
    res.sorted = model_in_order;
  endtask

  // Expected result words, oldest first.
  result_t     expected_places [$];
  result_t     last_result;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t ns: result word %0d, %s: got %0h, expected %0h",
               $realtime, words_checked, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Each word waits a drawn number of cycles before it is offered.
  // The mode is redrawn every 40 words so that stretches with no gaps occur too.
  // ---------------------------------------------------------------------------
  int unsigned driver_mode  = 0;
  int unsigned sink_mode    = 0;
  bit          sender_burst = 1'b0;
  bit          hold_output  = 1'b0;

  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, with
  // in_valid still high so that a following word can go out without a gap.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                           input logic [ID_W-1:0] gid, input bit use_typed = 1'b0,
                           input result_t typed_want = '0);
    int unsigned gap;
    result_t     res;
    if (words_sent % 40 == 0) driver_mode = $urandom_range(0, 2);
    gap = sender_burst ? 0 : draw_gap(driver_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_group_size <= size;
    in_group_id   <= gid;
    do @(posedge clk); while (!in_ready);
    predict_placement(cmd, size, gid, res);
    // Rows of the directed table that carry a typed-in answer use it instead.
    last_result = use_typed ? typed_want : res;
    expected_places.push_back(last_result);
    words_sent++;
    @(negedge clk);
  endtask

  // Drops in_valid and waits until every result is back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_places.size() != 0);
  endtask

  function automatic logic [SIZE_W-1:0] pick_group_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return SIZE_W'($urandom);
    if (pick == 1) return SIZE_W'($urandom_range(0, 4000));
    return SIZE_W'($urandom_range(0, 6));
  endfunction

  // Noise: bad ids, arbitrary ids, the ignored command and stray loads.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0:       send_word(CMD_PLACE, SIZE_W'($urandom), '0);
      1:       send_word(CMD_PLACE, SIZE_W'($urandom), ID_W'($urandom));
      2:       send_word(CMD_UNKNOWN, SIZE_W'($urandom), ID_W'($urandom));
      default: send_word(CMD_LOAD, pick_group_size(), ID_W'($urandom));
    endcase
  endtask

  // One batch: usually a clear, a handful of loads, then rows. Most batches place
  // rows group by group in order, which keeps the in-order flag up when each group is
  // filled exactly; others place rows in random groups (with overruns) or are mostly noise.
  task automatic run_batch();
    logic [SIZE_W-1:0] sizes [$];
    logic [SIZE_W-1:0] sz;
    int unsigned       base;
    int unsigned       kind;
    int unsigned       reps;
    int unsigned       top_id;
    if ($urandom_range(0, 9) != 0) send_word(CMD_CLEAR, SIZE_W'($urandom), ID_W'($urandom));
    base = model_loaded;
    repeat ($urandom_range(1, 12)) begin
      sz = pick_group_size();
      send_word(CMD_LOAD, sz, ID_W'($urandom));
      if (last_result.error == ERR_OK) sizes.push_back(sz);
    end
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      foreach (sizes[k]) begin
        reps = (sizes[k] > 8) ? 8 : sizes[k];
        repeat (reps) begin
          if ($urandom_range(0, 11) == 0) send_noise();
          send_word(CMD_PLACE, SIZE_W'($urandom), ID_W'(base + k + 1));
        end
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 30)) begin
        top_id = (model_loaded > 1023) ? 1023 : model_loaded;
        if (top_id != 0)
          send_word(CMD_PLACE, SIZE_W'($urandom), ID_W'($urandom_range(1, top_id)));
        else
          send_noise();
      end
    end else begin
      repeat ($urandom_range(4, 20)) send_noise();
    end
  endtask

  // Loads every table entry, then tries two more loads (the table-full case, which
  // takes precedence over an overflowing size) and places rows into high groups.
  task automatic fill_group_table();
    send_word(CMD_CLEAR, SIZE_W'($urandom), ID_W'($urandom));
    repeat (MAX_GROUPS) send_word(CMD_LOAD, SIZE_W'($urandom_range(0, 3)), ID_W'($urandom));
    send_word(CMD_LOAD, SIZE_W'($urandom_range(0, 15)), ID_W'($urandom));
    send_word(CMD_LOAD, '1, ID_W'($urandom));
    send_word(CMD_PLACE, SIZE_W'($urandom), '1);
    send_word(CMD_PLACE, SIZE_W'($urandom), ID_W'(512));
    repeat (20) send_word(CMD_PLACE, SIZE_W'($urandom), ID_W'($urandom_range(1, 1023)));
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. A row with typed set carries an answer that is plain from
  // the command alone; the others are left to the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   gid;
    bit                typed;
    result_t           want;
  } directed_row_t;

  directed_row_t directed_rows [NUM_DIRECTED];

  function automatic directed_row_t dir_row(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                                            logic [ID_W-1:0] gid, bit typed,
                                            logic [POS_W-1:0] pos, logic sorted, err_t err);
    directed_row_t r;
    r.cmd   = cmd;
    r.size  = size;
    r.gid   = gid;
    r.typed = typed;
    r.want  = '{position: pos, sorted: sorted, error: err};
    return r;
  endfunction

  initial begin : directed_table
    // Place before any load: the id is out of range, so no cursor is used.
    directed_rows[0]  = dir_row(CMD_PLACE,   20'd0,       10'd1,    1, 20'd0,       1, ERR_BAD_ID);
    // The ignored command reports the current flag and nothing else.
    directed_rows[1]  = dir_row(CMD_UNKNOWN, 20'hFFFFF,   10'h3FF,  1, 20'd0,       1, ERR_OK);
    directed_rows[2]  = dir_row(CMD_LOAD,    20'd3,       10'd0,    1, 20'd0,       1, ERR_OK);
    directed_rows[3]  = dir_row(CMD_LOAD,    20'd2,       10'd0,    1, 20'd3,       1, ERR_OK);
    directed_rows[4]  = dir_row(CMD_PLACE,   20'd0,       10'd1,    1, 20'd1,       1, ERR_OK);
    directed_rows[5]  = dir_row(CMD_PLACE,   20'd0,       10'd1,    1, 20'd2,       1, ERR_OK);
    // A row out of its original order drops the flag for the rest of the batch.
    directed_rows[6]  = dir_row(CMD_PLACE,   20'd0,       10'd2,    0, 20'd0,       0, ERR_OK);
    directed_rows[7]  = dir_row(CMD_PLACE,   20'd0,       10'd1,    0, 20'd0,       0, ERR_OK);
    // Id zero, one past the loaded groups, and the largest id are all rejected.
    directed_rows[8]  = dir_row(CMD_PLACE,   20'd0,       10'd0,    1, 20'd0,       0, ERR_BAD_ID);
    directed_rows[9]  = dir_row(CMD_PLACE,   20'd0,       10'd3,    1, 20'd0,       0, ERR_BAD_ID);
    directed_rows[10] = dir_row(CMD_PLACE,   20'd0,       10'h3FF,  1, 20'd0,       0, ERR_BAD_ID);
    directed_rows[11] = dir_row(CMD_CLEAR,   20'hFFFFF,   10'h3FF,  1, 20'd0,       1, ERR_OK);
    // Two loads that fill the row space exactly, then two that overflow it.
    directed_rows[12] = dir_row(CMD_LOAD,    20'h80000,   10'd0,    1, 20'd0,       1, ERR_OK);
    directed_rows[13] = dir_row(CMD_LOAD,    20'h7FFFF,   10'd0,    1, 20'h80000,   1, ERR_OK);
    directed_rows[14] = dir_row(CMD_LOAD,    20'd1,       10'd0,    1, 20'd0,       1, ERR_OVF);
    directed_rows[15] = dir_row(CMD_LOAD,    20'hFFFFF,   10'd0,    1, 20'd0,       1, ERR_OVF);
    // An empty group still fits and starts at the top of the row space.
    directed_rows[16] = dir_row(CMD_LOAD,    20'd0,       10'd0,    1, 20'hFFFFF,   1, ERR_OK);
    directed_rows[17] = dir_row(CMD_PLACE,   20'd0,       10'd1,    1, 20'd1,       1, ERR_OK);
    // Overrunning the empty last group wraps its cursor to zero.
    directed_rows[18] = dir_row(CMD_PLACE,   20'd0,       10'd3,    0, 20'd0,       0, ERR_OK);
    directed_rows[19] = dir_row(CMD_PLACE,   20'd0,       10'd2,    0, 20'd0,       0, ERR_OK);
    directed_rows[20] = dir_row(CMD_UNKNOWN, 20'd0,       10'd0,    0, 20'd0,       0, ERR_OK);
    directed_rows[21] = dir_row(CMD_CLEAR,   20'd0,       10'd0,    1, 20'd0,       1, ERR_OK);
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random batches, drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned drain_cycles;
    bit          table_filled;
    bit          congested;
    table_filled = 1'b0;
    congested    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].cmd, directed_rows[i].size, directed_rows[i].gid,
                directed_rows[i].typed, directed_rows[i].want);

    while (words_sent < ITEM_TARGET) begin
      if (!congested && words_sent > 150) begin
        // The output side holds off for a long stretch while words keep coming
        // back to back, so the pipeline fills and in_ready must drop.
        congested    = 1'b1;
        hold_output  = 1'b1;
        sender_burst = 1'b1;
        repeat (16) send_noise();
        repeat (3) run_batch();
        sender_burst = 1'b0;
      end else if (!table_filled && words_sent > 300) begin
        // Pause the input until every result is back, then fill the table.
        table_filled = 1'b1;
        wait_for_results();
        fill_group_table();
      end else begin
        run_batch();
      end
    end

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_places.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    // Keep watching the output so that a surplus word would still be caught.
    repeat (10) @(posedge clk);
    while (expected_places.size() != 0) begin
      report_mismatch("missing word", '0, expected_places[0].position);
      void'(expected_places.pop_front());
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: draws a stall before each word, serves one long hold when asked,
  // and compares each accepted word with the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    result_t     want;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      if (words_checked % 40 == 0) sink_mode = $urandom_range(0, 2);
      gap = draw_gap(sink_mode);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_places.size() == 0) begin
        report_mismatch("word with nothing expected", 32'(out_position), '0);
      end else begin
        want = expected_places.pop_front();
        if (out_position !== want.position)
          report_mismatch("position", 32'(out_position), 32'(want.position));
        if (out_sorted_so_far !== want.sorted)
          report_mismatch("sorted_so_far", 32'(out_sorted_so_far), 32'(want.sorted));
        if (out_error !== want.error)
          report_mismatch("error", 32'(out_error), 32'(want.error));
      end
      words_checked++;
      @(negedge clk);
    end
  end

endmodule

@@ filelist.f @@
hw/rtl/csra_pkg.sv
hw/rtl/csra_cursor_ram.sv
hw/rtl/csra_exec.sv
hw/rtl/counting_sort_rank_assign.sv
sim/counting_sort_rank_assign_tb.sv
